FILE: hdl/atids_pkg.sv
// ----------------------------------------------------------------------------
// atids_pkg
// Shared constants, command and status codes, and controller states for the
// array table insert, delete and search unit.
// ----------------------------------------------------------------------------
package atids_pkg;

  localparam int DEPTH   = 32;
  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int DW      = 16;
  localparam int CMD_W   = 3;
  localparam int POS_W   = 5;
  localparam int IDX_W   = 5;
  localparam int CNT_W   = 6;
  localparam int STAT_W  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 3'd0,
    CMD_INSERT  = 3'd1,
    CMD_DELMIN  = 3'd2,
    CMD_LSEARCH = 3'd3,
    CMD_BSEARCH = 3'd4,
    CMD_CLEAR   = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_BADPOS   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS,
    S_INS_PUT,
    S_DSCAN,
    S_DPREP,
    S_DSHIFT,
    S_LIN,
    S_BIN_ADDR,
    S_BIN_CMP,
    S_FIN
  } fsm_t;

endpackage

FILE: hdl/array_table_insert_delete_search_unit.sv
// ----------------------------------------------------------------------------
// array_table_insert_delete_search_unit
// Ordered table of signed 16-bit values with append, insert, delete-minimum,
// linear search, binary search and clear commands, held in one synchronous
// memory and processed one transaction at a time.
// ----------------------------------------------------------------------------
// The unit takes one command transaction at a time and returns exactly one
// result transaction for it. The table lives in a single memory with one
// write and one registered read per cycle, so the time a command takes
// follows the number of entries touched: append, clear and rejected
// commands touch none beyond the write, insert shifts entries up from the
// end to the position (none when it lands at the end), delete minimum scans
// and then shifts down, linear search reads until a match or the end and
// binary search halves the range until a match or an empty range. A new
// command is accepted while a finished result still waits on out_stall.
module array_table_insert_delete_search_unit
  import atids_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [CMD_W-1:0]        in_cmd,
  input  logic signed [DW-1:0]    in_value,
  input  logic [POS_W-1:0]        in_position,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [STAT_W-1:0]       out_status,
  output logic [IDX_W-1:0]        out_index,
  output logic signed [DW-1:0]    out_value_out,
  output logic [CNT_W-1:0]        out_count
);

  logic signed [DW-1:0] mem [DEPTH];
  logic signed [DW-1:0] rdata_r;

  fsm_t                 state_r, state_nxt;
  logic [AW-1:0]        ptr_r, ptr_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        lo_r, lo_nxt;
  logic [CW-1:0]        hx_r, hx_nxt;
  logic [AW-1:0]        mid_r, mid_nxt;
  logic signed [DW-1:0] key_r, key_nxt;
  logic signed [DW-1:0] min_r, min_nxt;
  status_t              res_status_r, res_status_nxt;
  logic [AW-1:0]        res_idx_r, res_idx_nxt;
  logic signed [DW-1:0] res_val_r, res_val_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]    out_status_r, out_status_nxt;
  logic [IDX_W-1:0]     out_index_r, out_index_nxt;
  logic signed [DW-1:0] out_value_r, out_value_nxt;
  logic [CNT_W-1:0]     out_count_r, out_count_nxt;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic signed [DW-1:0] wr_data;
  logic [AW-1:0]        rd_addr;
  logic                 in_acc;
  logic [CW:0]          mid_sum;

  assign in_stall      = (state_r != S_IDLE);
  assign in_acc        = in_valid && !in_stall;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_index     = out_index_r;
  assign out_value_out = out_value_r;
  assign out_count     = out_count_r;
  assign mid_sum       = {1'b0, lo_r} + {1'b0, hx_r} - (CW+1)'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    pos_r        <= pos_nxt;
    idx_r        <= idx_nxt;
    lo_r         <= lo_nxt;
    hx_r         <= hx_nxt;
    mid_r        <= mid_nxt;
    key_r        <= key_nxt;
    min_r        <= min_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_val_r    <= res_val_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    pos_nxt        = pos_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    lo_nxt         = lo_r;
    hx_nxt         = hx_r;
    mid_nxt        = mid_r;
    key_nxt        = key_r;
    min_nxt        = min_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_val_nxt    = res_val_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    wr_en          = 1'b0;
    wr_addr        = ptr_r;
    wr_data        = key_r;
    rd_addr        = ptr_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          key_nxt        = in_value;
          pos_nxt        = AW'(in_position);
          res_status_nxt = ST_OK;
          res_idx_nxt    = '0;
          res_val_nxt    = '0;
          state_nxt      = S_FIN;
          unique case (in_cmd)
            CMD_APPEND: begin
              if (cnt_r == CW'(DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = AW'(cnt_r);
                wr_data = in_value;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            CMD_INSERT: begin
              if (cnt_r == CW'(DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else if (CW'(in_position) > cnt_r) begin
                res_status_nxt = ST_BADPOS;
              end else if (CW'(in_position) == cnt_r) begin
                wr_en   = 1'b1;
                wr_addr = AW'(cnt_r);
                wr_data = in_value;
                cnt_nxt = cnt_r + CW'(1);
              end else begin
                ptr_nxt   = AW'(cnt_r - CW'(1));
                rd_addr   = AW'(cnt_r - CW'(1));
                state_nxt = S_INS;
              end
            end
            CMD_DELMIN: begin
              if (cnt_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                ptr_nxt   = '0;
                rd_addr   = '0;
                idx_nxt   = '0;
                state_nxt = S_DSCAN;
              end
            end
            CMD_LSEARCH: begin
              if (cnt_r == '0) begin
                res_status_nxt = ST_NOTFOUND;
              end else begin
                ptr_nxt   = '0;
                rd_addr   = '0;
                state_nxt = S_LIN;
              end
            end
            CMD_BSEARCH: begin
              lo_nxt    = '0;
              hx_nxt    = cnt_r;
              state_nxt = S_BIN_ADDR;
            end
            CMD_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r + AW'(1);
        wr_data = rdata_r;
        if (ptr_r == pos_r) begin
          state_nxt = S_INS_PUT;
        end else begin
          ptr_nxt = ptr_r - AW'(1);
          rd_addr = ptr_r - AW'(1);
        end
      end

      S_INS_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r;
        wr_data   = key_r;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = S_FIN;
      end

      S_DSCAN: begin
        if (ptr_r == '0 || rdata_r < min_r) begin
          min_nxt = rdata_r;
          idx_nxt = ptr_r;
        end
        if (CW'(ptr_r) + CW'(1) == cnt_r) begin
          state_nxt = S_DPREP;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
          rd_addr = ptr_r + AW'(1);
        end
      end

      S_DPREP: begin
        res_idx_nxt = idx_r;
        res_val_nxt = min_r;
        if (CW'(idx_r) + CW'(1) < cnt_r) begin
          ptr_nxt   = idx_r + AW'(1);
          rd_addr   = idx_r + AW'(1);
          state_nxt = S_DSHIFT;
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_FIN;
        end
      end

      S_DSHIFT: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r - AW'(1);
        wr_data = rdata_r;
        if (CW'(ptr_r) + CW'(1) < cnt_r) begin
          ptr_nxt = ptr_r + AW'(1);
          rd_addr = ptr_r + AW'(1);
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_FIN;
        end
      end

      S_LIN: begin
        if (rdata_r == key_r) begin
          res_idx_nxt = ptr_r;
          state_nxt   = S_FIN;
        end else if (CW'(ptr_r) + CW'(1) == cnt_r) begin
          res_status_nxt = ST_NOTFOUND;
          state_nxt      = S_FIN;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
          rd_addr = ptr_r + AW'(1);
        end
      end

      S_BIN_ADDR: begin
        if (lo_r < hx_r) begin
          mid_nxt   = AW'(mid_sum >> 1);
          rd_addr   = AW'(mid_sum >> 1);
          state_nxt = S_BIN_CMP;
        end else begin
          res_status_nxt = ST_NOTFOUND;
          state_nxt      = S_FIN;
        end
      end

      S_BIN_CMP: begin
        if (rdata_r == key_r) begin
          res_idx_nxt = mid_r;
          state_nxt   = S_FIN;
        end else begin
          if (rdata_r < key_r) begin
            lo_nxt = CW'(mid_r) + CW'(1);
          end else begin
            hx_nxt = CW'(mid_r);
          end
          state_nxt = S_BIN_ADDR;
        end
      end

      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_index_nxt  = IDX_W'(res_idx_r);
          out_value_nxt  = res_val_r;
          out_count_nxt  = CNT_W'(cnt_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count exceeds the table depth");

  a_write_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (CW'(wr_addr) <= cnt_r))
    else $error("memory write beyond the filled part of the table");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("accepted transaction did not start processing");

  a_mid_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BIN_CMP) |-> (CW'(mid_r) < cnt_r))
    else $error("binary search probe outside the filled entries");

endmodule
